FILE: hdl/cfc_pkg.sv
// Package for the CRC-32 command frame checker.
// Holds buffer sizing, CRC-32 constants, status codes and the byte-wide CRC update.
// No dependencies.
`default_nettype none

package cfc_pkg;

  localparam int BUFFER_SIZE = 1024;
  // Counter width able to hold BUFFER_SIZE itself
  localparam int CNT_W = $clog2(BUFFER_SIZE + 1);
  localparam int TOO_LONG_LIMIT = BUFFER_SIZE - 5;

  localparam int LEN_W = 11;
  localparam int LEN_MAX = (1 << LEN_W) - 1;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [31:0] CRC_XOROUT = 32'hFFFFFFFF;

  // "EXIT", first character in the top byte
  localparam logic [31:0] EXIT_WORD = 32'h45584954;

  typedef enum logic [1:0] {
    STATUS_VALID        = 2'd0,
    STATUS_TOO_LONG     = 2'd1,
    STATUS_CRC_MISMATCH = 2'd2
  } status_t;

  // Reflected CRC-32 update over one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Character of the EXIT word at position idx
  function automatic logic [7:0] exit_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = EXIT_WORD[31:24];
      2'd1:    ch = EXIT_WORD[23:16];
      2'd2:    ch = EXIT_WORD[15:8];
      default: ch = EXIT_WORD[7:0];
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/cfc_if.sv
// Valid/ready channel interfaces for the CRC-32 command frame checker.
// Byte input channel and per-datagram result channel; uses cfc_pkg for widths.
`default_nettype none

interface cfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cfc_out_if import cfc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic             exit_request;
  logic [LEN_W-1:0] payload_length;

  modport source (output valid, output status, output exit_request, output payload_length,
                  input ready);
  modport sink (input valid, input status, input exit_request, input payload_length,
                output ready);
endinterface

`default_nettype wire

FILE: hdl/crc32_command_frame_checker_top.sv
// Top level of the CRC-32 command frame checker.
// Depends on cfc_pkg (constants, CRC update) and cfc_if.sv (channel interfaces).
//
//   channel  dir  transaction              payload
//   in_ch    in   one datagram byte        data_byte[7:0], last_byte
//   out_ch   out  one verdict per datagram status[1:0], exit_request, payload_length[10:0]
//
// One byte per cycle unless in_ch stalls: the CRC-32 byte update and the frame
// counters advance at the edge a byte is taken; the last byte also loads the verdict
// into the output register at that same edge, so out_ch.valid rises the next cycle,
// and the frame state returns to its reset values.
// Reset (rst_n low, synchronous) clears frame state and the output valid.
// in_ch stalls only while a verdict sits unclaimed in the output register.
`default_nettype none

module crc32_command_frame_checker_top import cfc_pkg::*; (
  input  wire      clk,
  input  wire      rst_n,
  cfc_in_if.sink   in_ch,
  cfc_out_if.source out_ch
);

  typedef enum logic [1:0] {
    PH_PAYLOAD = 2'd0,
    PH_CRC     = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [31:0]      rcv_r, rcv_nxt;
  logic [2:0]       seen_r, seen_nxt;
  logic             match_r, match_nxt;
  logic [CNT_W-1:0] taken_r, taken_nxt;

  logic             out_valid_r;
  status_t          status_r, status_nxt;
  logic             exit_r, exit_nxt;
  logic [LEN_W-1:0] plen_r, plen_nxt;

  logic             in_fire;
  logic             skip;
  logic [31:0]      rcv_aligned;
  logic [31:0]      crc_final;
  logic [CNT_W+LEN_W-1:0] len_ext;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign skip        = (taken_r >= CNT_W'(BUFFER_SIZE));

  always_comb begin
    phase_nxt = phase_r;
    crc_nxt   = crc_r;
    len_nxt   = len_r;
    rcv_nxt   = rcv_r;
    seen_nxt  = seen_r;
    match_nxt = match_r;
    taken_nxt = taken_r;
    if (!skip) begin
      if (taken_r < CNT_W'(4) && in_ch.data_byte != exit_char(taken_r[1:0])) begin
        match_nxt = 1'b0;
      end
      taken_nxt = taken_r + CNT_W'(1);
      case (phase_r)
        PH_PAYLOAD: begin
          if (in_ch.data_byte == 8'd0) begin
            phase_nxt = PH_CRC;
          end else begin
            crc_nxt = crc_byte(crc_r, in_ch.data_byte);
            len_nxt = len_r + CNT_W'(1);
          end
        end
        PH_CRC: begin
          rcv_nxt  = {rcv_r[23:0], in_ch.data_byte};
          seen_nxt = seen_r + 3'd1;
          if (seen_r >= 3'd3) begin
            phase_nxt = PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // Missing CRC bytes read as zero: left-align what was collected
  always_comb begin
    case (seen_nxt)
      3'd0:    rcv_aligned = 32'd0;
      3'd1:    rcv_aligned = {rcv_nxt[7:0], 24'd0};
      3'd2:    rcv_aligned = {rcv_nxt[15:0], 16'd0};
      3'd3:    rcv_aligned = {rcv_nxt[23:0], 8'd0};
      default: rcv_aligned = rcv_nxt;
    endcase
  end

  assign crc_final = crc_nxt ^ CRC_XOROUT;
  assign len_ext   = {{LEN_W{1'b0}}, len_nxt};

  always_comb begin
    if (len_nxt > CNT_W'(TOO_LONG_LIMIT)) begin
      status_nxt = STATUS_TOO_LONG;
    end else if (crc_final != rcv_aligned) begin
      status_nxt = STATUS_CRC_MISMATCH;
    end else begin
      status_nxt = STATUS_VALID;
    end
    exit_nxt = (status_nxt == STATUS_VALID) && match_nxt && (taken_nxt >= CNT_W'(4));
    if (len_ext > (CNT_W+LEN_W)'(LEN_MAX)) begin
      plen_nxt = LEN_W'(LEN_MAX);
    end else begin
      plen_nxt = len_ext[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_PAYLOAD;
      crc_r       <= CRC_INIT;
      len_r       <= '0;
      rcv_r       <= '0;
      seen_r      <= '0;
      match_r     <= 1'b1;
      taken_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        if (in_ch.last_byte) begin
          // Datagram done: restart frame state
          phase_r <= PH_PAYLOAD;
          crc_r   <= CRC_INIT;
          len_r   <= '0;
          rcv_r   <= '0;
          seen_r  <= '0;
          match_r <= 1'b1;
          taken_r <= '0;
        end else begin
          phase_r <= phase_nxt;
          crc_r   <= crc_nxt;
          len_r   <= len_nxt;
          rcv_r   <= rcv_nxt;
          seen_r  <= seen_nxt;
          match_r <= match_nxt;
          taken_r <= taken_nxt;
        end
      end
      if (in_fire && in_ch.last_byte) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Verdict payload, loaded with the last byte of a datagram
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.last_byte) begin
      status_r <= status_nxt;
      exit_r   <= exit_nxt;
      plen_r   <= plen_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.exit_request   = exit_r;
  assign out_ch.payload_length = plen_r;

endmodule

`default_nettype wire
